// ===== rtl/rcpa_pkg.sv =====
package rcpa_pkg;

  localparam int NUM_PAGES_DEF  = 4096;
  localparam int COUNT_BITS_DEF = 8;

  localparam int PAGE_W     = 12;
  localparam int END_W      = 13;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int REFOUT_W   = 8;
  localparam int FCOUNT_W   = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INCR  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DECR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_PAGE   = 1'd1;

  localparam logic [PAGE_W-1:0] FIRST_PAGE_RST = 12'd0;
  localparam logic [END_W-1:0]  END_PAGE_RST   = 13'd4096;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PAGE_W-1:0] page;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   alloc_page;
    logic [REFOUT_W-1:0] ref_count;
    logic [FCOUNT_W-1:0] free_count;
    logic                list_empty;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;
    logic accept;
    logic exec;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage

// ===== rtl/rcpa_ram.sv =====
module rcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rcpa_ctrl.sv =====
module rcpa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output rcpa_pkg::cmd_t  cmd,
  input  rcpa_pkg::sts_t  sts
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy       = (state != ST_IDLE);
  assign cmd.clr    = (state == ST_CLEAR);
  assign cmd.accept = (state == ST_IDLE) && start;
  assign cmd.exec   = (state == ST_EXEC);

  a_exec_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> $past(cmd.accept))
    else $error("exec without a preceding accept");

  a_clear_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(cmd.clr) |-> $past(sts.clr_last))
    else $error("clearing pass ended early");

  a_exec_single: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> !cmd.exec)
    else $error("exec held for two cycles");

endmodule

// ===== rtl/rcpa_dp.sv =====
module rcpa_dp #(
  parameter int NUM_PAGES  = rcpa_pkg::NUM_PAGES_DEF,
  parameter int COUNT_BITS = rcpa_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rcpa_pkg::cmd_t                    cmd,
  output rcpa_pkg::sts_t                    sts,
  input  rcpa_pkg::req_t                    req,
  output logic                              done,
  output rcpa_pkg::res_t                    result,
  input  logic                              cfg_we,
  input  logic [rcpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int TW = $clog2(NUM_PAGES + 1);

  logic [rcpa_pkg::PAGE_W-1:0] first_page;
  logic [rcpa_pkg::END_W-1:0]  end_page;
  logic [TW-1:0]               top, top_next;
  logic [PW-1:0]               clr_addr;
  rcpa_pkg::req_t              req_q;
  rcpa_pkg::res_t              res_next;

  logic                  stk_we;
  logic [PW-1:0]         stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic                  refs_we, op_refs_we;
  logic [PW-1:0]         refs_waddr, op_refs_waddr, refs_raddr;
  logic [COUNT_BITS-1:0] refs_wdata, op_refs_wdata, refs_rdata;

  logic [COUNT_BITS-1:0] cnt, cnt_dec, cnt_inc, cnt_new;
  logic                  in_range, stack_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_page <= rcpa_pkg::FIRST_PAGE_RST;
      end_page   <= rcpa_pkg::END_PAGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rcpa_pkg::CFG_FIRST_PAGE: first_page <= cfg_data[rcpa_pkg::PAGE_W-1:0];
        rcpa_pkg::CFG_END_PAGE:   end_page   <= cfg_data;
        default: ;
      endcase
    end
  end

  // both memories are read on the accept edge; data is ready in the exec cycle
  assign stk_raddr  = PW'(top - TW'(1));
  assign refs_raddr = PW'(req.page);

  rcpa_ram #(.WIDTH(PW), .DEPTH(NUM_PAGES)) u_stack_ram (
    .clk   (clk),
    .we    (cmd.exec && stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  rcpa_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_PAGES)) u_refs_ram (
    .clk   (clk),
    .we    (refs_we),
    .waddr (refs_waddr),
    .wdata (refs_wdata),
    .raddr (refs_raddr),
    .rdata (refs_rdata)
  );

  assign cnt        = refs_rdata;
  assign cnt_dec    = (cnt != '0) ? cnt - COUNT_BITS'(1) : cnt;
  assign cnt_inc    = (cnt != '1) ? cnt + COUNT_BITS'(1) : cnt;
  assign stack_full = (top == TW'(NUM_PAGES));
  assign in_range   = (req_q.page >= first_page)
                   && (rcpa_pkg::END_W'(req_q.page) < end_page)
                   && (32'(req_q.page) < 32'(NUM_PAGES));

  always_comb begin
    res_next      = '0;
    res_next.status = rcpa_pkg::STAT_OK;
    top_next      = top;
    op_refs_we    = 1'b0;
    op_refs_waddr = PW'(req_q.page);
    op_refs_wdata = cnt;
    stk_we        = 1'b0;
    stk_waddr     = PW'(top);
    stk_wdata     = PW'(req_q.page);
    cnt_new       = '0;

    case (req_q.kind)
      rcpa_pkg::KIND_ALLOC: begin
        if (top == '0) begin
          res_next.status = rcpa_pkg::STAT_EMPTY;
        end else begin
          top_next            = top - TW'(1);
          op_refs_we          = 1'b1;
          op_refs_waddr       = stk_rdata;
          op_refs_wdata       = COUNT_BITS'(1);
          cnt_new             = COUNT_BITS'(1);
          res_next.alloc_page = rcpa_pkg::PAGE_W'(stk_rdata);
        end
      end
      rcpa_pkg::KIND_FREE, rcpa_pkg::KIND_INCR, rcpa_pkg::KIND_DECR,
      rcpa_pkg::KIND_QUERY: begin
        if (!in_range) begin
          res_next.status = rcpa_pkg::STAT_RANGE;
        end else begin
          cnt_new = cnt;
          if (req_q.kind == rcpa_pkg::KIND_INCR) begin
            cnt_new    = cnt_inc;
            op_refs_we = 1'b1;
          end else if (req_q.kind != rcpa_pkg::KIND_QUERY) begin
            cnt_new    = cnt_dec;
            op_refs_we = 1'b1;
          end
          op_refs_wdata = cnt_new;
          // a free that drops the count to zero returns the page to the stack
          if (req_q.kind == rcpa_pkg::KIND_FREE && cnt_new == '0) begin
            if (stack_full) begin
              res_next.status = rcpa_pkg::STAT_FULL;
            end else begin
              stk_we   = 1'b1;
              top_next = top + TW'(1);
            end
          end
        end
      end
      default: ;
    endcase

    res_next.ref_count  = rcpa_pkg::REFOUT_W'(cnt_new);
    res_next.free_count = rcpa_pkg::FCOUNT_W'(top_next);
    res_next.list_empty = (top_next == '0);
  end

  // the clearing pass owns the count memory write port after reset
  always_comb begin
    if (cmd.clr) begin
      refs_we    = 1'b1;
      refs_waddr = clr_addr;
      refs_wdata = '0;
    end else begin
      refs_we    = cmd.exec && op_refs_we;
      refs_waddr = op_refs_waddr;
      refs_wdata = op_refs_wdata;
    end
  end

  assign sts.clr_last = (clr_addr == PW'(NUM_PAGES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      top      <= '0;
      done     <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_addr <= clr_addr + PW'(1);
      end
      if (cmd.exec) begin
        top <= top_next;
      end
      done <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= req;
    end
    if (cmd.exec) begin
      result <= res_next;
    end
  end

  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    top <= TW'(NUM_PAGES))
    else $error("free stack pointer past capacity");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.exec))
    else $error("result strobe without an executed item");

  a_alloc_pops: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && req_q.kind == rcpa_pkg::KIND_ALLOC && top != '0)
      |=> (top == $past(top) - TW'(1)))
    else $error("alloc did not pop the free stack");

endmodule

// ===== rtl/refcounted_page_allocator.sv =====
// Reference-counted page allocator: a LIFO free stack of page numbers plus a
// per-page count table, both in single-port-write RAMs with registered reads.
// An item (kind, page) is taken at a clock edge with start high and busy low;
// both RAMs are read on that edge, the next cycle computes and writes back,
// and the result appears on result with done high for one cycle right after.
// No new item is taken until the last one has done its RAM write-back.
// The receiver cannot stall: every done cycle must be consumed. After reset a
// clearing pass zeroes every count table entry, with busy high throughout;
// first_page and end_page may be written at any idle time.
module refcounted_page_allocator #(
  parameter int NUM_PAGES  = rcpa_pkg::NUM_PAGES_DEF,
  parameter int COUNT_BITS = rcpa_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  rcpa_pkg::req_t                  req,
  output logic                            done,
  output rcpa_pkg::res_t                  result,
  input  logic                            cfg_we,
  input  logic [rcpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcpa_pkg::CFG_DATA_W-1:0] cfg_data
);

  rcpa_pkg::cmd_t cmd;
  rcpa_pkg::sts_t sts;

  rcpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  rcpa_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
